[sv/tlpm_pkg.sv]
// Package for the two-level page map and lookup block.
// Holds the request and response types, status codes, state encoding and
// fixed address-field widths. No dependencies.
package tlpm_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int DIR_ENTRIES     = 512;
    localparam int TABLE_ENTRIES   = 1024;

    localparam int DIR_IDX_W = 9;               // virt_addr[30:22]
    localparam int DIR_AW    = DIR_IDX_W + 1;   // user and kernel directories side by side
    localparam int TI_W      = 10;              // virt_addr[21:12]
    localparam int PPN_W     = 20;
    localparam int PR_W      = 2;
    localparam int ENT_W     = 1 + PR_W + PPN_W;
    localparam int SWEEP_W   = (DIR_AW > TI_W) ? DIR_AW : TI_W;

    localparam logic       REQ_MAP    = 1'b0;
    localparam logic       REQ_LOOKUP = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNMAPPED = 2'd1;
    localparam logic [1:0] STAT_BAD_AREA = 2'd2;
    localparam logic [1:0] STAT_NO_SLOT  = 2'd3;

    // Area codes from virt_addr[31:29]; everything with bit 31 clear is U0.
    localparam logic [2:0] AREA_P1 = 3'b100;
    localparam logic [2:0] AREA_P2 = 3'b101;
    localparam logic [2:0] AREA_P3 = 3'b110;

    typedef struct packed {
        logic        req_type;
        logic [31:0] virt_addr;
        logic [31:0] map_phys_addr;
        logic [1:0]  lock_flags;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys_addr;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_TAB,
        ST_FILL,
        ST_RESP
    } state_t;

endpackage

[sv/two_level_page_map_and_lookup.sv]
// Two-level page table with map and lookup requests, built around a directory
// memory and a table memory, both synchronous with registered read data.
// Depends on tlpm_pkg.
//
// After reset the block clears all 2*DIR_ENTRIES = 1024 entries of its directory
// memory, one entry a cycle, with in_ready low. After that one request is worked
// on at a time. A lookup in P1 or P2, any request that fails at the directory,
// and a map whose directory entry is already valid finish after the accept and
// the directory read. A lookup that walks both levels does a directory read,
// then a table read. A map that needs a new table also sweeps all TABLE_ENTRIES
// entries of the new table slot one by one through the single write port of the
// table memory. A response that finds the output register still occupied waits
// until it drains.
module two_level_page_map_and_lookup #(
    parameter int TABLE_SLOTS = tlpm_pkg::TABLE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tlpm_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tlpm_pkg::rsp_t out_data
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W  = 1 + SLOT_W;
    localparam int TAB_AW = $clog2(TABLE_SLOTS * tlpm_pkg::TABLE_ENTRIES);
    localparam int TA_W   = SLOT_W + tlpm_pkg::TI_W;

    tlpm_pkg::state_t state_reg, state_next;

    logic [tlpm_pkg::SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;

    logic                         req_type_reg;
    logic [31:0]                  va_reg;
    logic [tlpm_pkg::ENT_W-1:0]   ent_reg;

    logic                         out_valid_reg, out_valid_next;
    tlpm_pkg::rsp_t               out_data_reg, out_data_next;
    tlpm_pkg::rsp_t               hold_reg, hold_next;

    logic [DIR_W-1:0]             dir_mem [2*tlpm_pkg::DIR_ENTRIES];
    logic [DIR_W-1:0]             dir_rd_reg;
    logic [tlpm_pkg::ENT_W-1:0]   tab_mem [TABLE_SLOTS*tlpm_pkg::TABLE_ENTRIES];
    logic [tlpm_pkg::ENT_W-1:0]   tab_rd_reg;

    logic                         dir_re, dir_we;
    logic [tlpm_pkg::DIR_AW-1:0]  dir_addr;
    logic [DIR_W-1:0]             dir_wdata;
    logic                         tab_re, tab_we;
    logic [TA_W-1:0]              tab_addr;
    logic [tlpm_pkg::ENT_W-1:0]   tab_wdata;

    logic                         done, go_fill, go_tab;
    tlpm_pkg::rsp_t               done_rsp;

    logic [2:0]                   area;
    logic                         is_kern, is_walk, is_p1, is_p2;
    logic                         dir_valid;
    logic [SLOT_W-1:0]            dir_slot;
    logic [tlpm_pkg::TI_W-1:0]    ti;
    logic                         pool_empty;
    logic                         sweep_last_dir, sweep_last_tab;
    logic                         out_free;
    logic                         in_kern;

    assign area       = va_reg[31:29];
    assign is_kern    = (area == tlpm_pkg::AREA_P3);
    assign is_walk    = !va_reg[31] || is_kern;
    assign is_p1      = (area == tlpm_pkg::AREA_P1);
    assign is_p2      = (area == tlpm_pkg::AREA_P2);
    assign ti         = va_reg[21:12];
    assign dir_valid  = dir_rd_reg[DIR_W-1];
    assign dir_slot   = dir_rd_reg[SLOT_W-1:0];
    assign pool_empty = (cnt_reg >= CNT_W'(TABLE_SLOTS));
    assign out_free   = !out_valid_reg || out_ready;
    assign in_kern    = (in_data.virt_addr[31:29] == tlpm_pkg::AREA_P3);

    assign sweep_last_dir = (sweep_reg[tlpm_pkg::DIR_AW-1:0] == '1);
    assign sweep_last_tab = (sweep_reg[tlpm_pkg::TI_W-1:0] == '1);

    // Memories. Reads and writes never touch the same entry in one cycle: a
    // request is accepted only in the idle state, after all writes of the
    // previous request have landed.
    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_addr] <= dir_wdata;
        end
        if (dir_re)
        begin
            dir_rd_reg <= dir_mem[dir_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_addr[TAB_AW-1:0]] <= tab_wdata;
        end
        if (tab_re)
        begin
            tab_rd_reg <= tab_mem[tab_addr[TAB_AW-1:0]];
        end
    end

    // Memory control and the response of the current request.
    always_comb
    begin
        in_ready  = 1'b0;
        dir_re    = 1'b0;
        dir_we    = 1'b0;
        dir_addr  = {is_kern, va_reg[30:22]};
        dir_wdata = '0;
        tab_re    = 1'b0;
        tab_we    = 1'b0;
        tab_addr  = {dir_slot, ti};
        tab_wdata = ent_reg;
        done      = 1'b0;
        go_fill   = 1'b0;
        go_tab    = 1'b0;
        done_rsp  = '{status: tlpm_pkg::STAT_OK, phys_addr: 32'd0};

        case (state_reg)
            tlpm_pkg::ST_CLEAR:
            begin
                dir_we   = 1'b1;
                dir_addr = sweep_reg[tlpm_pkg::DIR_AW-1:0];
            end
            tlpm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                dir_re   = in_valid;
                dir_addr = {in_kern, in_data.virt_addr[30:22]};
            end
            tlpm_pkg::ST_DIR:
            begin
                if (req_type_reg == tlpm_pkg::REQ_LOOKUP)
                begin
                    if (is_p1)
                    begin
                        done               = 1'b1;
                        done_rsp.phys_addr = {1'b0, va_reg[30:0]};
                    end
                    else if (is_p2)
                    begin
                        done               = 1'b1;
                        done_rsp.phys_addr = {3'b000, va_reg[28:0]};
                    end
                    else if (!is_walk)
                    begin
                        done            = 1'b1;
                        done_rsp.status = tlpm_pkg::STAT_BAD_AREA;
                    end
                    else if (!dir_valid)
                    begin
                        done            = 1'b1;
                        done_rsp.status = tlpm_pkg::STAT_UNMAPPED;
                    end
                    else
                    begin
                        go_tab = 1'b1;
                        tab_re = 1'b1;
                    end
                end
                else
                begin
                    if (!is_walk)
                    begin
                        done            = 1'b1;
                        done_rsp.status = tlpm_pkg::STAT_BAD_AREA;
                    end
                    else if (dir_valid)
                    begin
                        done   = 1'b1;
                        tab_we = 1'b1;
                    end
                    else if (pool_empty)
                    begin
                        done            = 1'b1;
                        done_rsp.status = tlpm_pkg::STAT_NO_SLOT;
                    end
                    else
                    begin
                        go_fill   = 1'b1;
                        dir_we    = 1'b1;
                        dir_wdata = {1'b1, cnt_reg[SLOT_W-1:0]};
                    end
                end
            end
            tlpm_pkg::ST_TAB:
            begin
                done = 1'b1;
                if (tab_rd_reg[tlpm_pkg::ENT_W-1])
                begin
                    done_rsp.phys_addr = {tab_rd_reg[tlpm_pkg::PPN_W-1:0], 12'd0};
                end
                else
                begin
                    done_rsp.status = tlpm_pkg::STAT_UNMAPPED;
                end
            end
            tlpm_pkg::ST_FILL:
            begin
                // The sweep clears the new table and drops the mapped entry
                // in on its way past.
                tab_we   = 1'b1;
                tab_addr = {slot_reg, sweep_reg[tlpm_pkg::TI_W-1:0]};
                if (sweep_reg[tlpm_pkg::TI_W-1:0] != ti)
                begin
                    tab_wdata = '0;
                end
                done = sweep_last_tab;
            end
            tlpm_pkg::ST_RESP:
            begin
                done_rsp = hold_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlpm_pkg::ST_CLEAR:
            begin
                if (sweep_last_dir)
                begin
                    state_next = tlpm_pkg::ST_IDLE;
                end
            end
            tlpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tlpm_pkg::ST_DIR;
                end
            end
            tlpm_pkg::ST_DIR, tlpm_pkg::ST_TAB, tlpm_pkg::ST_FILL:
            begin
                if (go_tab)
                begin
                    state_next = tlpm_pkg::ST_TAB;
                end
                else if (go_fill)
                begin
                    state_next = tlpm_pkg::ST_FILL;
                end
                else if (done)
                begin
                    state_next = out_free ? tlpm_pkg::ST_IDLE : tlpm_pkg::ST_RESP;
                end
            end
            tlpm_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = tlpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlpm_pkg::ST_CLEAR;
            end
        endcase
    end

    // Next values of counters and the output register.
    always_comb
    begin
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (state_reg == tlpm_pkg::ST_CLEAR)
        begin
            sweep_next = sweep_last_dir ? '0 : sweep_reg + 1'b1;
        end
        if (state_reg == tlpm_pkg::ST_FILL)
        begin
            sweep_next = sweep_last_tab ? '0 : sweep_reg + 1'b1;
        end
        if (go_fill)
        begin
            sweep_next = '0;
            slot_next  = cnt_reg[SLOT_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
        end
        if (state_reg == tlpm_pkg::ST_RESP || done)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = done_rsp;
            end
            else
            begin
                hold_next = done_rsp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpm_pkg::ST_CLEAR;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
        if (in_valid && in_ready)
        begin
            req_type_reg <= in_data.req_type;
            va_reg       <= in_data.virt_addr;
            // Protection: kernel-only keeps the writable bit alone, otherwise
            // the user bit is set as well.
            ent_reg      <= {1'b1, !in_data.lock_flags[1], in_data.lock_flags[0],
                             in_data.map_phys_addr[31:12]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlpm_pkg::ST_CLEAR) |-> !in_ready)
        else $error("request accepted during directory clear");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_SLOTS))
        else $error("table slot count beyond pool size");

    a_err_phys_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.status == tlpm_pkg::STAT_OK
                           || out_data_reg.phys_addr == 32'd0))
        else $error("error response carries a nonzero address");

    a_tab_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        tab_we |-> (state_reg == tlpm_pkg::ST_DIR || state_reg == tlpm_pkg::ST_FILL))
        else $error("table write outside a map");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        go_fill |=> (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("slot allocation did not advance the pool");

endmodule
